[sv/esds_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package esds_pkg;

  // descriptor tags
  localparam logic [7:0] TagEsDesc   = 8'h03;
  localparam logic [7:0] TagDecCfg   = 8'h04;
  localparam logic [7:0] TagDecSpec  = 8'h05;

  // object type indications
  localparam logic [7:0] OtiAac      = 8'h40;
  localparam logic [7:0] OtiMp3      = 8'h6B;

  // ES descriptor flag bits
  localparam int unsigned FlagDepBit = 7;
  localparam int unsigned FlagUrlBit = 6;
  localparam int unsigned FlagOcrBit = 5;

  // continuation bit of a length byte
  localparam int unsigned LenMoreBit = 7;

  // codec codes
  localparam logic [1:0] CodecUnknown = 2'd0;
  localparam logic [1:0] CodecAac     = 2'd1;
  localparam logic [1:0] CodecMp3     = 2'd2;

  localparam logic [63:0] SizeLarge = 64'd1;

endpackage

`default_nettype wire

[sv/esds_box_descriptor_parser.sv]
// esds box descriptor parser.
// Input channel (in_valid_i / in_ready_o): one byte of an esds box per item,
// box_start_i high on the first byte of a box. A start byte always aborts any
// parse in progress and is taken as the first size byte.
// Output channel (out_valid_o / out_ready_i): at most one result item per box, made
// on the byte that ends the parse (end of DecoderConfig length when that descriptor
// is absent, end of DecSpecificInfo length when not AAC with one, else the second
// AudioSpecificConfig byte). Bytes after that are dropped until the next start.
// Throughput: one byte per cycle while in_ready_o is high; the per-byte work is
// the phase decoder and a 64-bit byte accumulator, all resolved in the accept cycle.
// Latency: the result is shown the cycle after the final byte is accepted,
// held in an output register.
// Reset: parser idle, waiting for a start byte; no result pending.
// Receiver stall: input keeps flowing while the output register is empty or
// being drained; with a result held and out_ready_i low, in_ready_o drops.
// A header size of 0 is flagged on size_to_end_o, not resolved.
`timescale 1ns / 1ps
`default_nettype none

module esds_box_descriptor_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        box_start_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      box_size_o,
  output logic             size_to_end_o,
  output logic [31:0]      box_type_o,
  output logic [7:0]       obj_type_ind_o,
  output logic [1:0]       codec_o,
  output logic [31:0]      max_bitrate_o,
  output logic [31:0]      avg_bitrate_o,
  output logic             asc_valid_o,
  output logic [4:0]       audio_object_type_o,
  output logic [3:0]       sampling_index_o,
  output logic [3:0]       channel_config_o
);
  import esds_pkg::*;

  typedef enum logic [4:0] {
    PhIdle, PhSize, PhType, PhLarge, PhVerf, PhEsTag, PhEsLen, PhEsId,
    PhEsFlags, PhDep, PhUrlLen, PhUrl, PhOcr, PhDcTag, PhDcLen, PhOti,
    PhStream, PhBuf, PhMax, PhAvg, PhDsiTag, PhDsiLen, PhAsc
  } phase_e;

  // where to go after the ES flag skips, from a given skip stage on
  function automatic phase_e flag_next(input logic [1:0] stage, input logic [7:0] flags);
    phase_e ph;
    if (stage == 2'd0 && flags[FlagDepBit]) begin
      ph = PhDep;
    end else if (stage <= 2'd1 && flags[FlagUrlBit]) begin
      ph = PhUrlLen;
    end else if (flags[FlagOcrBit]) begin
      ph = PhOcr;
    end else begin
      ph = PhDcTag;
    end
    return ph;
  endfunction

  // parser state
  phase_e      phase_q, phase_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [63:0] fsh_q, fsh_d;
  logic [2:0]  lcnt_q, lcnt_d;
  logic [7:0]  tag_q, tag_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  skip_q, skip_d;
  logic [63:0] size_q, size_d;
  logic [31:0] type_q, type_d;
  logic [7:0]  oti_q, oti_d;
  logic [31:0] maxr_q, maxr_d;
  logic [31:0] avgr_q, avgr_d;
  logic        to_end_q, to_end_d;

  // state as seen by this byte (cleared by a start)
  phase_e      cur_phase;
  logic [3:0]  cur_fcnt;
  logic [63:0] cur_fsh;
  logic [2:0]  cur_lcnt;

  logic        in_acc;
  logic [63:0] sh_next;
  logic [3:0]  cnt_inc;
  logic        len_done;
  logic        emit_c;
  logic        asc_c;

  // output register
  logic        out_valid_q;
  logic [63:0] o_size_q;
  logic        o_to_end_q;
  logic [31:0] o_type_q;
  logic [7:0]  o_oti_q;
  logic [1:0]  o_codec_q;
  logic [31:0] o_maxr_q;
  logic [31:0] o_avgr_q;
  logic        o_asc_q;
  logic [15:0] o_asc_word_q;
  logic [1:0]  codec_c;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    // start byte wipes the parse and enters the size field
    cur_phase = box_start_i ? PhSize : phase_q;
    cur_fcnt  = box_start_i ? 4'd0 : fcnt_q;
    cur_fsh   = box_start_i ? 64'd0 : fsh_q;
    cur_lcnt  = box_start_i ? 3'd0 : lcnt_q;
    tag_d     = box_start_i ? 8'd0 : tag_q;
    flags_d   = box_start_i ? 8'd0 : flags_q;
    skip_d    = box_start_i ? 8'd0 : skip_q;
    size_d    = box_start_i ? 64'd0 : size_q;
    type_d    = box_start_i ? 32'd0 : type_q;
    oti_d     = box_start_i ? 8'd0 : oti_q;
    maxr_d    = box_start_i ? 32'd0 : maxr_q;
    avgr_d    = box_start_i ? 32'd0 : avgr_q;
    to_end_d  = box_start_i ? 1'b0 : to_end_q;

    phase_d  = cur_phase;
    fcnt_d   = cur_fcnt;
    fsh_d    = cur_fsh;
    lcnt_d   = cur_lcnt;
    emit_c   = 1'b0;
    asc_c    = 1'b0;

    sh_next  = {cur_fsh[55:0], data_byte_i};
    cnt_inc  = cur_fcnt + 4'd1;
    len_done = !data_byte_i[LenMoreBit] || (cur_lcnt == 3'd3);

    unique case (cur_phase)
      PhSize: begin
        fsh_d  = sh_next;
        fcnt_d = cnt_inc;
        if (cnt_inc == 4'd4) begin
          fcnt_d   = 4'd0;
          size_d   = {32'd0, sh_next[31:0]};
          to_end_d = (sh_next[31:0] == 32'd0);
          phase_d  = PhType;
        end
      end
      PhType: begin
        fsh_d  = sh_next;
        fcnt_d = cnt_inc;
        if (cnt_inc == 4'd4) begin
          fcnt_d  = 4'd0;
          type_d  = sh_next[31:0];
          phase_d = (size_d == SizeLarge) ? PhLarge : PhVerf;
        end
      end
      PhLarge: begin
        fsh_d  = sh_next;
        fcnt_d = cnt_inc;
        if (cnt_inc == 4'd8) begin
          fcnt_d  = 4'd0;
          size_d  = sh_next;
          phase_d = PhVerf;
        end
      end
      PhVerf: begin
        fsh_d  = sh_next;
        fcnt_d = cnt_inc;
        if (cnt_inc == 4'd4) begin
          fcnt_d  = 4'd0;
          phase_d = PhEsTag;
        end
      end
      PhEsTag: begin
        tag_d   = data_byte_i;
        phase_d = PhEsLen;
      end
      PhEsLen: begin
        lcnt_d = cur_lcnt + 3'd1;
        if (len_done) begin
          lcnt_d  = 3'd0;
          phase_d = PhEsId;
        end
      end
      PhEsId: begin
        fsh_d  = sh_next;
        fcnt_d = cnt_inc;
        if (cnt_inc == 4'd2) begin
          fcnt_d  = 4'd0;
          phase_d = (tag_d == TagEsDesc) ? PhEsFlags : PhDcTag;
        end
      end
      PhEsFlags: begin
        flags_d = data_byte_i;
        phase_d = flag_next(2'd0, data_byte_i);
      end
      PhDep: begin
        fsh_d  = sh_next;
        fcnt_d = cnt_inc;
        if (cnt_inc == 4'd2) begin
          fcnt_d  = 4'd0;
          phase_d = flag_next(2'd1, flags_d);
        end
      end
      PhUrlLen: begin
        skip_d  = data_byte_i;
        phase_d = (data_byte_i != 8'd0) ? PhUrl : flag_next(2'd2, flags_d);
      end
      PhUrl: begin
        skip_d = skip_d - 8'd1;
        if (skip_d == 8'd0) begin
          phase_d = flag_next(2'd2, flags_d);
        end
      end
      PhOcr: begin
        fsh_d  = sh_next;
        fcnt_d = cnt_inc;
        if (cnt_inc == 4'd2) begin
          fcnt_d  = 4'd0;
          phase_d = PhDcTag;
        end
      end
      PhDcTag: begin
        tag_d   = data_byte_i;
        phase_d = PhDcLen;
      end
      PhDcLen: begin
        lcnt_d = cur_lcnt + 3'd1;
        if (len_done) begin
          lcnt_d = 3'd0;
          if (tag_d == TagDecCfg) begin
            phase_d = PhOti;
          end else begin
            emit_c  = 1'b1;
            phase_d = PhIdle;
          end
        end
      end
      PhOti: begin
        oti_d   = data_byte_i;
        phase_d = PhStream;
      end
      PhStream: begin
        phase_d = PhBuf;
      end
      PhBuf: begin
        fsh_d  = sh_next;
        fcnt_d = cnt_inc;
        if (cnt_inc == 4'd3) begin
          fcnt_d  = 4'd0;
          phase_d = PhMax;
        end
      end
      PhMax: begin
        fsh_d  = sh_next;
        fcnt_d = cnt_inc;
        if (cnt_inc == 4'd4) begin
          fcnt_d  = 4'd0;
          maxr_d  = sh_next[31:0];
          phase_d = PhAvg;
        end
      end
      PhAvg: begin
        fsh_d  = sh_next;
        fcnt_d = cnt_inc;
        if (cnt_inc == 4'd4) begin
          fcnt_d  = 4'd0;
          avgr_d  = sh_next[31:0];
          phase_d = PhDsiTag;
        end
      end
      PhDsiTag: begin
        tag_d   = data_byte_i;
        phase_d = PhDsiLen;
      end
      PhDsiLen: begin
        lcnt_d = cur_lcnt + 3'd1;
        if (len_done) begin
          lcnt_d = 3'd0;
          if (oti_d == OtiAac && tag_d == TagDecSpec) begin
            phase_d = PhAsc;
          end else begin
            emit_c  = 1'b1;
            phase_d = PhIdle;
          end
        end
      end
      PhAsc: begin
        fsh_d  = sh_next;
        fcnt_d = cnt_inc;
        if (cnt_inc == 4'd2) begin
          fcnt_d  = 4'd0;
          emit_c  = 1'b1;
          asc_c   = 1'b1;
          phase_d = PhIdle;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  always_comb begin
    if (oti_d == OtiAac) begin
      codec_c = CodecAac;
    end else if (oti_d == OtiMp3) begin
      codec_c = CodecMp3;
    end else begin
      codec_c = CodecUnknown;
    end
  end

  // parser state: only the phase and counters need a reset, the rest is
  // cleared by the start byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      fcnt_q  <= 4'd0;
      lcnt_q  <= 3'd0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      fcnt_q  <= fcnt_d;
      lcnt_q  <= lcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fsh_q    <= fsh_d;
      tag_q    <= tag_d;
      flags_q  <= flags_d;
      skip_q   <= skip_d;
      size_q   <= size_d;
      type_q   <= type_d;
      oti_q    <= oti_d;
      maxr_q   <= maxr_d;
      avgr_q   <= avgr_d;
      to_end_q <= to_end_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && emit_c) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit_c) begin
      o_size_q     <= size_d;
      o_to_end_q   <= to_end_d;
      o_type_q     <= type_d;
      o_oti_q      <= oti_d;
      o_codec_q    <= codec_c;
      o_maxr_q     <= maxr_d;
      o_avgr_q     <= avgr_d;
      o_asc_q      <= asc_c;
      o_asc_word_q <= asc_c ? sh_next[15:0] : 16'd0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign box_size_o          = o_size_q;
  assign size_to_end_o       = o_to_end_q;
  assign box_type_o          = o_type_q;
  assign obj_type_ind_o      = o_oti_q;
  assign codec_o             = o_codec_q;
  assign max_bitrate_o       = o_maxr_q;
  assign avg_bitrate_o       = o_avgr_q;
  assign asc_valid_o         = o_asc_q;
  assign audio_object_type_o = o_asc_word_q[15:11];
  assign sampling_index_o    = o_asc_word_q[10:7];
  assign channel_config_o    = o_asc_word_q[6:3];

`ifndef ASSERT_OFF
  // a fresh result always follows an accepted byte
  a_result_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_i && in_ready_o))
    else $error("result without an accepted byte");

  // parser is idle once a result has been made
  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> phase_q == PhIdle)
    else $error("parser not idle after result");

  // AudioSpecificConfig is only read for AAC
  a_asc_is_aac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && asc_valid_o |-> codec_o == CodecAac)
    else $error("asc_valid without AAC codec");

  // header size of 0 leaves box size 0
  a_to_end_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && size_to_end_o |-> box_size_o == 64'd0)
    else $error("size_to_end with non-zero box size");

  // without a config read the AAC fields are zero
  a_asc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !asc_valid_o |-> audio_object_type_o == 5'd0 &&
      sampling_index_o == 4'd0 && channel_config_o == 4'd0)
    else $error("AAC fields set without config");
`endif

endmodule

`default_nettype wire

[tb/tb_esds_box_descriptor_parser.sv]
`timescale 1ns / 1ps

module tb_esds_box_descriptor_parser;
  import esds_pkg::*;

  localparam int unsigned RandomBytes = 1000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned CycleLimit  = 400000;

  typedef enum logic [4:0] {
    PhIdle, PhSize, PhType, PhLarge, PhVerf, PhEsTag, PhEsLen, PhEsId, PhEsFlags,
    PhDep, PhUrlLen, PhUrl, PhOcr, PhDcTag, PhDcLen, PhOti, PhStream, PhBuf,
    PhMax, PhAvg, PhDsiTag, PhDsiLen, PhAsc
  } parse_phase_e;

  typedef struct {
    logic [63:0] box_size;
    logic        size_to_end;
    logic [31:0] box_type;
    logic [7:0]  obj_type_ind;
    logic [1:0]  codec;
    logic [31:0] max_bitrate;
    logic [31:0] avg_bitrate;
    logic        asc_valid;
    logic [4:0]  audio_object_type;
    logic [3:0]  sampling_index;
    logic [3:0]  channel_config;
  } esds_result_t;

  // knobs for one generated box
  typedef struct {
    logic [31:0] hdr_size;
    logic [63:0] large_size;
    logic [31:0] box_type;
    logic [7:0]  es_tag;
    int unsigned es_len_n;
    logic [7:0]  es_flags;
    logic [7:0]  url_len;
    logic [7:0]  dc_tag;
    int unsigned dc_len_n;
    logic [7:0]  oti;
    logic [31:0] max_rate;
    logic [31:0] avg_rate;
    logic [7:0]  dsi_tag;
    int unsigned dsi_len_n;
    logic [15:0] asc;
    bit          len_ones;
  } box_recipe_t;

  typedef logic [7:0] byte_q_t[$];

  // Tracks the parse byte by byte and holds the results still to come.
  class esds_parse_board;
    parse_phase_e phase;
    logic [3:0]   field_cnt;
    logic [63:0]  field_acc;
    logic [2:0]   len_cnt;
    logic [7:0]   tag;
    logic [7:0]   es_flags;
    logic [7:0]   skip_left;
    logic [7:0]   oti;
    logic [63:0]  size_val;
    logic         to_end;
    logic [31:0]  btype;
    logic [31:0]  max_rate;
    logic [31:0]  avg_rate;
    esds_result_t expected_q[$];
    int unsigned  mismatches;

    function new();
      clear();
      mismatches  = 0;
    endfunction

    function void clear();
      phase     = PhIdle;
      field_cnt = '0;
      field_acc = '0;
      len_cnt   = '0;
      tag       = '0;
      es_flags  = '0;
      skip_left = '0;
      oti       = '0;
      size_val  = '0;
      to_end    = 1'b0;
      btype     = '0;
      max_rate  = '0;
      avg_rate  = '0;
    endfunction

    // shift a byte in; true once n bytes of the field are in
    function bit take(logic [7:0] b, int unsigned n);
      field_acc = {field_acc[55:0], b};
      field_cnt = field_cnt + 1'b1;
      if (field_cnt >= n) begin
        field_cnt = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // descriptor length: ends on a byte without the more bit, or the fourth
    function bit len_done(logic [7:0] b);
      len_cnt = len_cnt + 1'b1;
      if (!b[LenMoreBit] || len_cnt >= 4) begin
        len_cnt = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function parse_phase_e after_flags(int stage);
      if (stage <= 0 && es_flags[FlagDepBit]) return PhDep;
      if (stage <= 1 && es_flags[FlagUrlBit]) return PhUrlLen;
      if (stage <= 2 && es_flags[FlagOcrBit]) return PhOcr;
      return PhDcTag;
    endfunction

    function void finish_box(logic asc_ok, logic [15:0] cfg);
      esds_result_t r;
      r.box_size       = size_val;
      r.size_to_end    = to_end;
      r.box_type       = btype;
      r.obj_type_ind   = oti;
      r.codec          = (oti == OtiAac) ? CodecAac : (oti == OtiMp3) ? CodecMp3 : CodecUnknown;
      r.max_bitrate    = max_rate;
      r.avg_bitrate    = avg_rate;
      r.asc_valid      = asc_ok;
      r.audio_object_type = asc_ok ? cfg[15:11] : '0;
      r.sampling_index    = asc_ok ? cfg[10:7] : '0;
      r.channel_config    = asc_ok ? cfg[6:3] : '0;
      expected_q = {expected_q, r};
      phase = PhIdle;
    endfunction

    function void note_byte(logic [7:0] b, logic start);
      if (start) begin
        clear();
        phase = PhSize;
      end
      case (phase)
        PhSize: if (take(b, 4)) begin
          size_val = {32'd0, field_acc[31:0]};
          to_end   = (field_acc[31:0] == 32'd0);
          phase    = PhType;
        end
        PhType: if (take(b, 4)) begin
          btype = field_acc[31:0];
          phase = (size_val == SizeLarge) ? PhLarge : PhVerf;
        end
        PhLarge: if (take(b, 8)) begin
          size_val = field_acc;
          phase    = PhVerf;
        end
        PhVerf: if (take(b, 4)) phase = PhEsTag;
        PhEsTag: begin
          tag   = b;
          phase = PhEsLen;
        end
        PhEsLen: if (len_done(b)) phase = PhEsId;
        PhEsId: if (take(b, 2)) phase = (tag == TagEsDesc) ? PhEsFlags : PhDcTag;
        PhEsFlags: begin
          es_flags = b;
          phase    = after_flags(0);
        end
        PhDep: if (take(b, 2)) phase = after_flags(1);
        PhUrlLen: begin
          skip_left = b;
          phase     = (b != 8'd0) ? PhUrl : after_flags(2);
        end
        PhUrl: begin
          skip_left = skip_left - 1'b1;
          if (skip_left == 8'd0) phase = after_flags(2);
        end
        PhOcr: if (take(b, 2)) phase = PhDcTag;
        PhDcTag: begin
          tag   = b;
          phase = PhDcLen;
        end
        PhDcLen: if (len_done(b)) begin
          if (tag == TagDecCfg) phase = PhOti;
          else finish_box(1'b0, '0);
        end
        PhOti: begin
          oti   = b;
          phase = PhStream;
        end
        PhStream: phase = PhBuf;
        PhBuf: if (take(b, 3)) phase = PhMax;
        PhMax: if (take(b, 4)) begin
          max_rate = field_acc[31:0];
          phase    = PhAvg;
        end
        PhAvg: if (take(b, 4)) begin
          avg_rate = field_acc[31:0];
          phase    = PhDsiTag;
        end
        PhDsiTag: begin
          tag   = b;
          phase = PhDsiLen;
        end
        PhDsiLen: if (len_done(b)) begin
          if (oti == OtiAac && tag == TagDecSpec) phase = PhAsc;
          else finish_box(1'b0, '0);
        end
        PhAsc: if (take(b, 2)) finish_box(1'b1, field_acc[15:0]);
        default: phase = PhIdle;
      endcase
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(esds_result_t got);
      esds_result_t want;
      if (expected_q.size() == 0) begin
        $error("result item with none expected (box_size %0h)", got.box_size);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare("box_size", want.box_size, got.box_size);
      compare("size_to_end", want.size_to_end, got.size_to_end);
      compare("box_type", want.box_type, got.box_type);
      compare("obj_type_ind", want.obj_type_ind, got.obj_type_ind);
      compare("codec", want.codec, got.codec);
      compare("max_bitrate", want.max_bitrate, got.max_bitrate);
      compare("avg_bitrate", want.avg_bitrate, got.avg_bitrate);
      compare("asc_valid", want.asc_valid, got.asc_valid);
      compare("audio_object_type", want.audio_object_type, got.audio_object_type);
      compare("sampling_index", want.sampling_index, got.sampling_index);
      compare("channel_config", want.channel_config, got.channel_config);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        box_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] box_size_o;
  logic        size_to_end_o;
  logic [31:0] box_type_o;
  logic [7:0]  obj_type_ind_o;
  logic [1:0]  codec_o;
  logic [31:0] max_bitrate_o;
  logic [31:0] avg_bitrate_o;
  logic        asc_valid_o;
  logic [4:0]  audio_object_type_o;
  logic [3:0]  sampling_index_o;
  logic [3:0]  channel_config_o;

  esds_parse_board board;
  esds_result_t    seen;
  int unsigned     send_gap_pct = 0;
  int unsigned     stall_pct = 0;
  int unsigned     bytes_sent = 0;
  int unsigned     cycle_count = 0;

  esds_box_descriptor_parser dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .data_byte_i         (data_byte_i),
    .box_start_i         (box_start_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .box_size_o          (box_size_o),
    .size_to_end_o       (size_to_end_o),
    .box_type_o          (box_type_o),
    .obj_type_ind_o      (obj_type_ind_o),
    .codec_o             (codec_o),
    .max_bitrate_o       (max_bitrate_o),
    .avg_bitrate_o       (avg_bitrate_o),
    .asc_valid_o         (asc_valid_o),
    .audio_object_type_o (audio_object_type_o),
    .sampling_index_o    (sampling_index_o),
    .channel_config_o    (channel_config_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_esds_box_descriptor_parser failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // both channels sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen = '{box_size_o, size_to_end_o, box_type_o, obj_type_ind_o, codec_o,
                 max_bitrate_o, avg_bitrate_o, asc_valid_o, audio_object_type_o,
                 sampling_index_o, channel_config_o};
        board.check_result(seen);
      end
      if (in_valid_i && in_ready_o) board.note_byte(data_byte_i, box_start_i);
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic void push_len(ref byte_q_t q, input int unsigned n, input bit all_ones);
    logic [7:0] v;
    for (int unsigned i = 1; i <= n; i++) begin
      v = all_ones ? 8'hFF : rand_byte();
      if (i < n) v[LenMoreBit] = 1'b1;
      else if (n < 4) v[LenMoreBit] = 1'b0;
      q = {q, v};
    end
  endfunction

  function automatic box_recipe_t random_recipe();
    box_recipe_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) r.hdr_size = SizeLarge[31:0];
    else if (pick < 25) r.hdr_size = 32'd0;
    else r.hdr_size = $urandom;
    r.large_size = {$urandom, $urandom};
    if ($urandom_range(3) == 0) r.box_type = $urandom;
    else r.box_type = "esds";
    r.es_tag    = ($urandom_range(9) < 8) ? TagEsDesc : rand_byte();
    r.es_len_n  = $urandom_range(4, 1);
    r.es_flags  = rand_byte();
    // the odd long URL, otherwise short ones
    r.url_len   = ($urandom_range(9) == 0) ? rand_byte() : 8'($urandom_range(6));
    r.dc_tag    = ($urandom_range(9) < 8) ? TagDecCfg : rand_byte();
    r.dc_len_n  = $urandom_range(4, 1);
    pick = $urandom_range(99);
    if (pick < 45) r.oti = OtiAac;
    else if (pick < 70) r.oti = OtiMp3;
    else r.oti = rand_byte();
    r.max_rate  = $urandom;
    r.avg_rate  = $urandom;
    r.dsi_tag   = ($urandom_range(9) < 8) ? TagDecSpec : rand_byte();
    r.dsi_len_n = $urandom_range(4, 1);
    r.asc       = 16'($urandom);
    r.len_ones  = ($urandom_range(15) == 0);
    return r;
  endfunction

  function automatic byte_q_t build_box(box_recipe_t r);
    byte_q_t q;
    for (int i = 3; i >= 0; i--) q = {q, r.hdr_size[8*i +: 8]};
    for (int i = 3; i >= 0; i--) q = {q, r.box_type[8*i +: 8]};
    if (r.hdr_size == SizeLarge[31:0])
      for (int i = 7; i >= 0; i--) q = {q, r.large_size[8*i +: 8]};
    repeat (4) q = {q, rand_byte()};   // version and flags
    q = {q, r.es_tag};
    push_len(q, r.es_len_n, r.len_ones);
    repeat (2) q = {q, rand_byte()};   // ES id
    if (r.es_tag == TagEsDesc) begin
      q = {q, r.es_flags};
      if (r.es_flags[FlagDepBit]) repeat (2) q = {q, rand_byte()};
      if (r.es_flags[FlagUrlBit]) begin
        q = {q, r.url_len};
        repeat (r.url_len) q = {q, rand_byte()};
      end
      if (r.es_flags[FlagOcrBit]) repeat (2) q = {q, rand_byte()};
    end
    q = {q, r.dc_tag};
    push_len(q, r.dc_len_n, r.len_ones);
    if (r.dc_tag == TagDecCfg) begin
      q = {q, r.oti};
      repeat (4) q = {q, rand_byte()};   // stream type, buffer size
      for (int i = 3; i >= 0; i--) q = {q, r.max_rate[8*i +: 8]};
      for (int i = 3; i >= 0; i--) q = {q, r.avg_rate[8*i +: 8]};
      q = {q, r.dsi_tag};
      push_len(q, r.dsi_len_n, r.len_ones);
      if (r.oti == OtiAac && r.dsi_tag == TagDecSpec) begin
        q = {q, r.asc[15:8]};
        q = {q, r.asc[7:0]};
      end
    end
    return q;
  endfunction

  // one item; valid stays up until in_ready_o is seen at a rising edge
  task automatic send_byte(input logic [7:0] value, input logic first);
    int unsigned gap;
    gap = 0;
    while (gap < 8 && $urandom_range(99) < send_gap_pct) gap++;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= value;
    box_start_i <= first;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_box(input byte_q_t q, input int unsigned upto);
    for (int unsigned i = 0; i < upto && i < q.size(); i++) send_byte(q[i], i == 0);
    bytes_sent += upto;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic random_step();
    byte_q_t     q;
    int unsigned pick;
    q = build_box(random_recipe());
    pick = $urandom_range(99);
    if (pick < 75) begin
      send_box(q, q.size());
      repeat ($urandom_range(3)) send_byte(rand_byte(), 1'b0);   // dropped after the result
    end else if (pick < 90) begin
      // cut short; the next start aborts it
      send_box(q, $urandom_range(q.size() - 1, 1));
    end else begin
      repeat ($urandom_range(8, 1)) begin
        send_byte(rand_byte(), $urandom_range(3) == 0);
        bytes_sent++;
      end
    end
  endtask

  task automatic run_directed();
    box_recipe_t r;
    byte_q_t     q;
    // stray bytes before any start
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // AAC, header size 0, every ES skip with an empty URL, four-byte lengths of all ones
    r = random_recipe();
    r.hdr_size = '0; r.box_type = '1; r.es_tag = TagEsDesc; r.es_flags = 8'hFF;
    r.url_len = '0; r.es_len_n = 4; r.dc_len_n = 4; r.dsi_len_n = 4; r.len_ones = 1'b1;
    r.dc_tag = TagDecCfg; r.oti = OtiAac; r.max_rate = '1; r.avg_rate = '1;
    r.dsi_tag = TagDecSpec; r.asc = '1;
    q = build_box(r);
    send_box(q, q.size());
    send_byte(8'hFF, 1'b0);
    // largesize of all ones, MP3, longest URL
    r = random_recipe();
    r.hdr_size = SizeLarge[31:0]; r.large_size = '1; r.es_tag = TagEsDesc;
    r.es_flags = 8'h40; r.url_len = 8'hFF; r.es_len_n = 1; r.dc_len_n = 1;
    r.dsi_len_n = 1; r.len_ones = 1'b0; r.dc_tag = TagDecCfg; r.oti = OtiMp3;
    q = build_box(r);
    send_box(q, q.size());
    // largesize 0, no ES descriptor, no DecoderConfig: early result
    r = random_recipe();
    r.hdr_size = SizeLarge[31:0]; r.large_size = '0; r.es_tag = 8'h00; r.dc_tag = 8'h00;
    q = build_box(r);
    send_box(q, q.size());
    // AAC without DecSpecificInfo, dependency skip only
    r = random_recipe();
    r.hdr_size = '1; r.box_type = '0; r.es_tag = TagEsDesc; r.es_flags = 8'h80;
    r.dc_tag = TagDecCfg; r.oti = OtiAac; r.dsi_tag = 8'h06;
    q = build_box(r);
    send_box(q, q.size());
    // unknown object type with DecSpecificInfo tag, OCR skip only, zero rates
    r = random_recipe();
    r.es_tag = TagEsDesc; r.es_flags = 8'h20; r.dc_tag = TagDecCfg; r.oti = 8'h00;
    r.max_rate = '0; r.avg_rate = '0; r.dsi_tag = TagDecSpec;
    q = build_box(r);
    send_box(q, q.size());
    // start mid-parse, then a plain AAC box with zero config bytes
    send_box(q, 20);
    r = random_recipe();
    r.es_tag = TagEsDesc; r.es_flags = 8'h00; r.dc_tag = TagDecCfg; r.oti = OtiAac;
    r.dsi_tag = TagDecSpec; r.asc = '0;
    q = build_box(r);
    send_box(q, q.size());
    wait_drained();
  endtask

  initial begin
    int unsigned target_bytes;
    board = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    // idling phases: none, sender only, receiver only, both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 45; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 45; end
        default: begin send_gap_pct = 30; stall_pct = 30; end
      endcase
      target_bytes = bytes_sent + RandomBytes / 4;
      while (bytes_sent < target_bytes) random_step();
      // hold off until every pending result is out
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("tb_esds_box_descriptor_parser passed");
    end else begin
      $display("tb_esds_box_descriptor_parser failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/esds_pkg.sv
sv/esds_box_descriptor_parser.sv
tb/tb_esds_box_descriptor_parser.sv
